// File: rtl/ccbm_pkg.sv
// Shared types, codes and character helpers for the bracket character-class matcher.
// No dependencies; imported by every other RTL file.
`timescale 1ns / 1ps
`default_nettype none

package ccbm_pkg;

	localparam int MAP_BYTES = 16;
	localparam int MAP_BITS  = MAP_BYTES * 8;
	localparam int IDX_W     = $clog2(MAP_BITS);

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_QUERY   = 1'b1;

	localparam logic [1:0] ST_PENDING  = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_NO_CLOSE = 2'd2;
	localparam logic [1:0] ST_NO_SET   = 2'd3;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBR    = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	typedef struct packed {
		logic       op;
		logic [7:0] char_in;
		logic       pattern_end;
	} ccbm_in_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] status;
	} ccbm_out_t;

	typedef enum logic [2:0] {
		PH_BEFORE  = 3'd0,
		PH_OPEN    = 3'd1,
		PH_LEAD    = 3'd2,
		PH_LEADBR  = 3'd3,
		PH_BODY    = 3'd4,
		PH_DASH    = 3'd5,
		PH_ESC     = 3'd6,
		PH_STOPPED = 3'd7
	} phase_t;

	typedef enum logic {
		CTL_IDLE  = 1'b0,
		CTL_RANGE = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic step;
	} ccbm_cmd_t;

	typedef struct packed {
		logic range_req;
		logic range_done;
	} ccbm_stat_t;

	function automatic logic [7:0] escape_of(input logic [7:0] c);
		logic [7:0] e;
		case (c)
			8'h61:   e = 8'd7;
			8'h62:   e = 8'd8;
			8'h66:   e = 8'd12;
			8'h6E:   e = 8'd10;
			8'h72:   e = 8'd13;
			8'h74:   e = 8'd9;
			8'h76:   e = 8'd11;
			default: e = 8'd0;
		endcase
		return e;
	endfunction

	// map bits for one character, plus the other case of a letter when folding
	function automatic logic [MAP_BITS-1:0] char_bits(input logic [7:0] c, input logic cs);
		logic [MAP_BITS-1:0] m;
		logic [7:0]          alt;
		logic                other;
		m     = '0;
		alt   = c;
		other = 1'b0;
		m[c[IDX_W-1:0]] = 1'b1;
		if (!cs) begin
			if (c inside {[8'h61:8'h7A]}) begin
				alt   = c - CASE_GAP;
				other = 1'b1;
			end else if (c inside {[8'h41:8'h5A]}) begin
				alt   = c + CASE_GAP;
				other = 1'b1;
			end
		end
		if (other) begin
			m[alt[IDX_W-1:0]] = 1'b1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// File: rtl/ccbm_ctrl.sv
// Controller: handshake, output valid and range-fill sequencing.
// Depends on ccbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccbm_ctrl
	import ccbm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       out_stall,
	input  wire ccbm_stat_t stat,
	output logic            in_stall,
	output logic            out_valid,
	output ccbm_cmd_t       cmd
);

	ctl_state_t state_q, state_n;
	logic       out_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (cmd.accept && stat.range_req) begin
					state_n = CTL_RANGE;
				end
			end
			CTL_RANGE: begin
				if (stat.range_done) begin
					state_n = CTL_IDLE;
				end
			end
			default: state_n = CTL_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != CTL_IDLE) || (out_valid_q && out_stall);
		cmd.accept = in_valid && !in_stall;
		cmd.step   = (state_q == CTL_RANGE);
		out_valid  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ccbm_datapath.sv
// Datapath: bracket parser, building and committed maps, range counter, result register.
// Depends on ccbm_pkg; sequenced by ccbm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ccbm_datapath
	import ccbm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire ccbm_in_t in_data,
	input  wire ccbm_cmd_t cmd,
	output ccbm_stat_t    stat,
	output ccbm_out_t     out_data
);

	logic                 cs_q;
	phase_t               phase_q, phase_n;
	logic                 neg_q, neg_n;
	logic [7:0]           prev_q, prev_n;
	logic [MAP_BITS-1:0]  bmap_q, bmap_n;
	logic [MAP_BITS-1:0]  cmap_q, cmap_n;
	logic                 all_q, all_n;
	logic signed [8:0]    cnt_q, hi_q;
	ccbm_out_t            out_q;

	logic [1:0]           status_n;
	phase_t               ph;
	logic                 done;
	logic [7:0]           c;
	logic [7:0]           esc;
	logic                 pattern_acc;

	assign c           = in_data.char_in;
	assign esc         = escape_of(c);
	assign pattern_acc = cmd.accept && (in_data.op == OP_PATTERN);

	assign stat.range_req  = (in_data.op == OP_PATTERN) && !in_data.pattern_end &&
		(phase_q == PH_DASH) && (c != CH_RBR);
	assign stat.range_done = (cnt_q > hi_q);

	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		prev_n   = prev_q;
		bmap_n   = bmap_q;
		cmap_n   = cmap_q;
		all_n    = all_q;
		status_n = ST_PENDING;
		ph       = phase_q;
		done     = 1'b0;
		if (phase_q == PH_BEFORE) begin
			all_n  = 1'b0;
			neg_n  = 1'b0;
			prev_n = 8'd0;
			bmap_n = '0;
		end
		if (in_data.pattern_end) begin
			if (phase_q == PH_BEFORE) begin
				status_n = ST_NO_SET;
			end else if (phase_q != PH_STOPPED) begin
				status_n = ST_NO_CLOSE;
			end
			phase_n = PH_BEFORE;
		end else begin
			case (phase_q)
				PH_BEFORE: begin
					if (c == CH_STAR) begin
						all_n    = 1'b1;
						phase_n  = PH_STOPPED;
						status_n = ST_COMPLETE;
					end else if (c == CH_LBR) begin
						phase_n = PH_OPEN;
					end
				end
				PH_DASH: begin
					if (c == CH_RBR) begin
						cmap_n   = (bmap_n | char_bits(CH_DASH, cs_q)) ^ {MAP_BITS{neg_n}};
						bmap_n   = '0;
						phase_n  = PH_STOPPED;
						status_n = ST_COMPLETE;
					end else begin
						prev_n  = c;
						phase_n = PH_BODY;
					end
				end
				PH_ESC: begin
					bmap_n  = bmap_n | char_bits((esc != 8'd0) ? esc : c, cs_q);
					prev_n  = c;
					phase_n = PH_BODY;
				end
				PH_STOPPED: begin
					phase_n = PH_STOPPED;
				end
				default: begin
					if (ph == PH_OPEN) begin
						if (c == CH_CARET) begin
							neg_n   = 1'b1;
							phase_n = PH_LEAD;
							done    = 1'b1;
						end else begin
							ph = PH_LEAD;
						end
					end
					if (!done && ph == PH_LEAD) begin
						ph = PH_LEADBR;
						if (c == CH_DASH) begin
							bmap_n  = bmap_n | char_bits(c, 1'b1);
							prev_n  = c;
							phase_n = PH_LEADBR;
							done    = 1'b1;
						end
					end
					if (!done && ph == PH_LEADBR) begin
						ph = PH_BODY;
						if (c == CH_RBR) begin
							bmap_n  = bmap_n | char_bits(c, 1'b1);
							prev_n  = c;
							phase_n = PH_BODY;
							done    = 1'b1;
						end
					end
					if (!done) begin
						if (c == CH_RBR) begin
							cmap_n   = bmap_n ^ {MAP_BITS{neg_n}};
							bmap_n   = '0;
							phase_n  = PH_STOPPED;
							status_n = ST_COMPLETE;
						end else if (c == CH_DASH) begin
							phase_n = PH_DASH;
						end else if (c == CH_BSLASH) begin
							phase_n = PH_ESC;
						end else begin
							bmap_n  = bmap_n | char_bits(c, cs_q);
							prev_n  = c;
							phase_n = PH_BODY;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q    <= 1'b1;
			phase_q <= PH_BEFORE;
			neg_q   <= 1'b0;
			prev_q  <= 8'd0;
			bmap_q  <= '0;
			cmap_q  <= '0;
			all_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cs_q <= cfg_wdata;
			end
			if (pattern_acc) begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				prev_q  <= prev_n;
				bmap_q  <= bmap_n;
				cmap_q  <= cmap_n;
				all_q   <= all_n;
			end else if (cmd.step && !stat.range_done) begin
				bmap_q <= bmap_q | char_bits(cnt_q[7:0], cs_q);
			end
		end
	end

	// range counter: previous char + 1 up to end char, signed bytes
	always_ff @(posedge clk) begin
		if (pattern_acc && stat.range_req) begin
			cnt_q <= $signed({prev_q[7], prev_q}) + 9'sd1;
			hi_q  <= $signed({c[7], c});
		end else if (cmd.step && !stat.range_done) begin
			cnt_q <= cnt_q + 9'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (in_data.op == OP_QUERY) begin
				out_q.matched <= all_q | cmap_q[c[IDX_W-1:0]];
				out_q.status  <= ST_PENDING;
			end else begin
				out_q.matched <= 1'b0;
				out_q.status  <= status_n;
			end
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// File: rtl/char_class_bitmap_matcher_core.sv
// Top level of the bracket character-class matcher: controller plus datapath.
// Depends on ccbm_pkg, ccbm_ctrl, ccbm_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | in_valid / in_stall  | in_data  (op, char_in, pattern_end)
//  output   | out_valid / out_stall| out_data (matched, status)
//  config   | cfg_we               | cfg_wdata (case_sensitive)
//
// A new request is taken every cycle unless in_stall is high; only a range request (x-y)
// stalls the input itself, while the datapath counter sets one map bit per cycle for each
// value after x up to y, compared as signed bytes (up to 255 values).
// Results are registered; one output slot, so input stalls while a result waits stalled.
// arst_n clears parse state, both maps, match-all and sets case_sensitive to 1.
`timescale 1ns / 1ps
`default_nettype none

module char_class_bitmap_matcher_core
	import ccbm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire ccbm_in_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output ccbm_out_t     out_data
);

	ccbm_cmd_t  cmd;
	ccbm_stat_t stat;

	ccbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	ccbm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
